### hw/rtl/ppg_pkg.sv
// Shared widths, register indexes and payload types of the point-attractor particle step.
package ppg_pkg;

   // Fraction bits of the fixed-point position and velocity, usable from 8 to 24.
   localparam int FRAC_BITS = 16;

   localparam int WORD_W = 32;
   localparam int OFF_W  = WORD_W + 1;
   localparam int STR_W  = 16;
   localparam int SQ_W   = 2 * WORD_W;
   localparam int DSQ_W  = SQ_W + 1;
   localparam int DEN_W  = DSQ_W + 2;
   localparam int PROD_W = WORD_W + STR_W;
   localparam int NUM_W  = PROD_W + 2 * FRAC_BITS;
   localparam int QUO_W  = WORD_W;
   localparam int HEAD_W = NUM_W - QUO_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_X        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_Y        = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_STRENGTH = CSR_IDX_W'(2);

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_pos_x;
      logic signed [WORD_W-1:0] new_pos_y;
      logic signed [WORD_W-1:0] new_vel_x;
      logic signed [WORD_W-1:0] new_vel_y;
   } rsp_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] source_x;
      logic signed [WORD_W-1:0] source_y;
      logic [STR_W-1:0]         source_strength;
   } cfg_type;

   // request plus the sign of its offset to the attractor on each axis
   typedef struct packed {
      req_type item;
      logic    neg_x;
      logic    neg_y;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [DEN_W-1:0]    den;
      logic [PROD_W-1:0]   prod_x;
      logic [PROD_W-1:0]   prod_y;
   } geom_type;

   // one axis of the long division: partial remainder, dividend bits still to
   // shift in, quotient so far, quotient too large for 32 bits
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      side_type         side;
      logic [DEN_W-1:0] den;
      logic             den_zero;
      lane_type         lane_x;
      lane_type         lane_y;
   } div_type;

endpackage

### hw/rtl/ppg_geom.sv
// Offset, distance and numerator stages: five register stages ahead of the divider.
module ppg_geom (
   input  logic               clock,
   input  logic               reset,
   input  ppg_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppg_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ppg_pkg::geom_type  out_data
);

   localparam int STAGES = 5;

   typedef struct packed {
      ppg_pkg::req_type                 item;
      logic signed [ppg_pkg::OFF_W-1:0] dx;
      logic signed [ppg_pkg::OFF_W-1:0] dy;
   } g1_type;

   typedef struct packed {
      ppg_pkg::side_type           side;
      logic [ppg_pkg::WORD_W-1:0]  ax;
      logic [ppg_pkg::WORD_W-1:0]  ay;
   } g2_type;

   typedef struct packed {
      ppg_pkg::side_type           side;
      logic [ppg_pkg::SQ_W-1:0]    sq_x;
      logic [ppg_pkg::SQ_W-1:0]    sq_y;
      logic [ppg_pkg::PROD_W-1:0]  prod_x;
      logic [ppg_pkg::PROD_W-1:0]  prod_y;
   } g3_type;

   typedef struct packed {
      ppg_pkg::side_type           side;
      logic [ppg_pkg::DSQ_W-1:0]   dsq;
      logic [ppg_pkg::PROD_W-1:0]  prod_x;
      logic [ppg_pkg::PROD_W-1:0]  prod_y;
   } g4_type;

   logic [STAGES-1:0] valid_ff, valid_in, en;

   g1_type            g1_ff, g1_in;
   g2_type            g2_ff, g2_in;
   g3_type            g3_ff, g3_in;
   g4_type            g4_ff, g4_in;
   ppg_pkg::geom_type g5_ff, g5_in;

   // a stage may load when some stage at or after it is empty or the tail drains
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = out_ready || !(&(valid_ff | ~({STAGES{1'b1}} << k)));
      end
   end

   assign valid_in  = (valid_ff & ~en) | ({valid_ff[STAGES-2:0], in_valid} & en);
   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = g5_ff;

   always_comb begin
      g1_in.item = in_data;
      g1_in.dx   = {cfg.source_x[ppg_pkg::WORD_W-1], cfg.source_x}
                 - {in_data.pos_x[ppg_pkg::WORD_W-1], in_data.pos_x};
      g1_in.dy   = {cfg.source_y[ppg_pkg::WORD_W-1], cfg.source_y}
                 - {in_data.pos_y[ppg_pkg::WORD_W-1], in_data.pos_y};

      g2_in.side.item  = g1_ff.item;
      g2_in.side.neg_x = g1_ff.dx[ppg_pkg::OFF_W-1];
      g2_in.side.neg_y = g1_ff.dy[ppg_pkg::OFF_W-1];
      g2_in.ax = g1_ff.dx[ppg_pkg::OFF_W-1] ? ppg_pkg::WORD_W'(-g1_ff.dx)
                                            : ppg_pkg::WORD_W'(g1_ff.dx);
      g2_in.ay = g1_ff.dy[ppg_pkg::OFF_W-1] ? ppg_pkg::WORD_W'(-g1_ff.dy)
                                            : ppg_pkg::WORD_W'(g1_ff.dy);

      g3_in.side   = g2_ff.side;
      g3_in.sq_x   = ppg_pkg::SQ_W'(g2_ff.ax) * ppg_pkg::SQ_W'(g2_ff.ax);
      g3_in.sq_y   = ppg_pkg::SQ_W'(g2_ff.ay) * ppg_pkg::SQ_W'(g2_ff.ay);
      g3_in.prod_x = ppg_pkg::PROD_W'(g2_ff.ax) * ppg_pkg::PROD_W'(cfg.source_strength);
      g3_in.prod_y = ppg_pkg::PROD_W'(g2_ff.ay) * ppg_pkg::PROD_W'(cfg.source_strength);

      g4_in.side   = g3_ff.side;
      g4_in.dsq    = ppg_pkg::DSQ_W'(g3_ff.sq_x) + ppg_pkg::DSQ_W'(g3_ff.sq_y);
      g4_in.prod_x = g3_ff.prod_x;
      g4_in.prod_y = g3_ff.prod_y;

      // three times the squared distance as d + 2d
      g5_in.side   = g4_ff.side;
      g5_in.den    = ppg_pkg::DEN_W'(g4_ff.dsq) + ppg_pkg::DEN_W'({g4_ff.dsq, 1'b0});
      g5_in.prod_x = g4_ff.prod_x;
      g5_in.prod_y = g4_ff.prod_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         g1_ff <= g1_in;
      end
      if (en[1]) begin
         g2_ff <= g2_in;
      end
      if (en[2]) begin
         g3_ff <= g3_in;
      end
      if (en[3]) begin
         g4_ff <= g4_in;
      end
      if (en[4]) begin
         g5_ff <= g5_in;
      end
   end

endmodule

### hw/rtl/ppg_div.sv
// Pipelined restoring divider: an overflow stage, then one quotient bit per stage on both axes.
module ppg_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppg_pkg::geom_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ppg_pkg::div_type   out_data
);

   localparam int STAGES = ppg_pkg::QUO_W + 1;

   logic [STAGES-1:0] valid_ff, valid_in, en;

   ppg_pkg::div_type stage_ff [STAGES];
   ppg_pkg::div_type stage_in [STAGES];

   // Split the scaled numerator: its upper part is the first partial remainder,
   // which must stay below the divisor for the quotient to fit 32 bits.
   function automatic ppg_pkg::lane_type lane_start(logic [ppg_pkg::PROD_W-1:0] prod,
                                                    logic [ppg_pkg::DEN_W-1:0] den);
      logic [ppg_pkg::NUM_W-1:0] num;
      ppg_pkg::lane_type         lane;
      num       = ppg_pkg::NUM_W'(prod) << (2 * ppg_pkg::FRAC_BITS);
      lane.rem  = ppg_pkg::DEN_W'(num[ppg_pkg::NUM_W-1:ppg_pkg::QUO_W]);
      lane.low  = num[ppg_pkg::QUO_W-1:0];
      lane.quo  = '0;
      lane.ovf  = lane.rem >= den;
      return lane;
   endfunction

   function automatic ppg_pkg::lane_type lane_step(ppg_pkg::lane_type lane,
                                                   logic [ppg_pkg::DEN_W-1:0] den);
      logic [ppg_pkg::DEN_W:0] trial;
      logic [ppg_pkg::DEN_W:0] diff;
      logic                    take;
      ppg_pkg::lane_type       nxt;
      trial    = {lane.rem, lane.low[ppg_pkg::QUO_W-1]};
      diff     = trial - {1'b0, den};
      take     = trial >= {1'b0, den};
      nxt      = lane;
      nxt.rem  = take ? diff[ppg_pkg::DEN_W-1:0] : trial[ppg_pkg::DEN_W-1:0];
      nxt.low  = {lane.low[ppg_pkg::QUO_W-2:0], 1'b0};
      nxt.quo  = {lane.quo[ppg_pkg::QUO_W-2:0], take};
      return nxt;
   endfunction

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = out_ready || !(&(valid_ff | ~({STAGES{1'b1}} << k)));
      end
   end

   assign valid_in  = (valid_ff & ~en) | ({valid_ff[STAGES-2:0], in_valid} & en);
   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = stage_ff[STAGES-1];

   always_comb begin
      stage_in[0].side     = in_data.side;
      stage_in[0].den      = in_data.den;
      stage_in[0].den_zero = in_data.den == '0;
      stage_in[0].lane_x   = lane_start(in_data.prod_x, in_data.den);
      stage_in[0].lane_y   = lane_start(in_data.prod_y, in_data.den);
      for (int k = 1; k < STAGES; k++) begin
         stage_in[k]        = stage_ff[k-1];
         stage_in[k].lane_x = lane_step(stage_ff[k-1].lane_x, stage_ff[k-1].den);
         stage_in[k].lane_y = lane_step(stage_ff[k-1].lane_y, stage_ff[k-1].den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

endmodule

### hw/rtl/ppg_update.sv
// Acceleration limit, velocity update, one percent damping and position update: six stages.
module ppg_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppg_pkg::div_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ppg_pkg::rsp_type   out_data
);

   localparam int STAGES = 6;
   localparam int W      = ppg_pkg::WORD_W;

   localparam logic [W-1:0] SMAX      = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN      = {1'b1, {(W-1){1'b0}}};
   // floor(x / 100) = (x * ceil(2^38 / 100)) >> 38 for every 32-bit x
   localparam int           RCP_SHIFT = 38;
   localparam logic [W-1:0] RCP_100   = 32'd2748779070;

   typedef struct packed {
      ppg_pkg::req_type item;
      logic [W-1:0]     acc_x;
      logic [W-1:0]     acc_y;
   } u1_type;

   typedef struct packed {
      ppg_pkg::req_type item;
      logic [W-1:0]     mag_x;
      logic [W-1:0]     mag_y;
   } u3_type;

   typedef struct packed {
      ppg_pkg::req_type item;
      logic [2*W-1:0]   prod_x;
      logic [2*W-1:0]   prod_y;
   } u4_type;

   logic [STAGES-1:0] valid_ff, valid_in, en;

   u1_type           u1_ff, u1_in;
   ppg_pkg::req_type u2_ff, u2_in;
   u3_type           u3_ff, u3_in;
   u4_type           u4_ff, u4_in;
   ppg_pkg::req_type u5_ff, u5_in;
   ppg_pkg::rsp_type u6_ff, u6_in;

   // Limit the quotient to 2^31 when the attractor lies on the negative side, 2^31-1 on the positive side.
   function automatic logic [W-1:0] accel(ppg_pkg::lane_type lane, logic neg, logic zero);
      logic         big;
      logic [W-1:0] acc;
      big = lane.ovf || (lane.quo > SMIN);
      if (zero) begin
         acc = '0;
      end else if (neg) begin
         acc = big ? SMIN : -lane.quo;
      end else begin
         acc = (big || lane.quo[W-1]) ? SMAX : lane.quo;
      end
      return acc;
   endfunction

   function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] sum;
      sum = {a[W-1], a} + {b[W-1], b};
      if (sum[W] != sum[W-1]) begin
         return sum[W] ? SMIN : SMAX;
      end
      return sum[W-1:0];
   endfunction

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = out_ready || !(&(valid_ff | ~({STAGES{1'b1}} << k)));
      end
   end

   assign valid_in  = (valid_ff & ~en) | ({valid_ff[STAGES-2:0], in_valid} & en);
   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = u6_ff;

   always_comb begin
      u1_in.item  = in_data.side.item;
      u1_in.acc_x = accel(in_data.lane_x, in_data.side.neg_x, in_data.den_zero);
      u1_in.acc_y = accel(in_data.lane_y, in_data.side.neg_y, in_data.den_zero);

      u2_in       = u1_ff.item;
      u2_in.vel_x = sat_add(u1_ff.item.vel_x, u1_ff.acc_x);
      u2_in.vel_y = sat_add(u1_ff.item.vel_y, u1_ff.acc_y);

      u3_in.item  = u2_ff;
      u3_in.mag_x = u2_ff.vel_x[W-1] ? -u2_ff.vel_x : u2_ff.vel_x;
      u3_in.mag_y = u2_ff.vel_y[W-1] ? -u2_ff.vel_y : u2_ff.vel_y;

      u4_in.item   = u3_ff.item;
      u4_in.prod_x = (2*W)'(u3_ff.mag_x) * (2*W)'(RCP_100);
      u4_in.prod_y = (2*W)'(u3_ff.mag_y) * (2*W)'(RCP_100);

      // damp toward zero by |v| / 100
      u5_in       = u4_ff.item;
      u5_in.vel_x = u4_ff.item.vel_x[W-1]
                  ? u4_ff.item.vel_x + W'(u4_ff.prod_x >> RCP_SHIFT)
                  : u4_ff.item.vel_x - W'(u4_ff.prod_x >> RCP_SHIFT);
      u5_in.vel_y = u4_ff.item.vel_y[W-1]
                  ? u4_ff.item.vel_y + W'(u4_ff.prod_y >> RCP_SHIFT)
                  : u4_ff.item.vel_y - W'(u4_ff.prod_y >> RCP_SHIFT);

      u6_in.new_pos_x = sat_add(u5_ff.pos_x, u5_ff.vel_x);
      u6_in.new_pos_y = sat_add(u5_ff.pos_y, u5_ff.vel_y);
      u6_in.new_vel_x = u5_ff.vel_x;
      u6_in.new_vel_y = u5_ff.vel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u1_ff <= u1_in;
      end
      if (en[1]) begin
         u2_ff <= u2_in;
      end
      if (en[2]) begin
         u3_ff <= u3_in;
      end
      if (en[3]) begin
         u4_ff <= u4_in;
      end
      if (en[4]) begin
         u5_ff <= u5_in;
      end
      if (en[5]) begin
         u6_ff <= u6_in;
      end
   end

endmodule

### hw/rtl/particle_point_gravity_step_top.sv
// Top level of the point-attractor particle step: register port and the three pipeline sections.
//
// One particle enters per clock while req_ready is high; its updated position and
// velocity leave the pipeline after three sections: five stages form the offsets,
// squared distance and numerators, 33 stages run the divider (an overflow stage,
// then one quotient bit per stage; the long division of offset times strength by
// three times the squared distance sets that depth), and six stages limit the
// acceleration, add it, damp the velocity and move the position. Every stage holds
// its own valid bit, so a stalled result only stops the stages behind it that are
// full; req_ready drops only when all 44 stages hold a particle and rsp_ready is
// low. The three attractor registers are written through the csr port, index 0
// source_x, 1 source_y, 2 source_strength (low 16 bits of the data); index 3 is
// ignored. Write them only with no particle in flight. All three reset to zero.
module particle_point_gravity_step_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ppg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ppg_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ppg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppg_pkg::WORD_W-1:0]     csr_data
);

   ppg_pkg::cfg_type  cfg_ff, cfg_in;

   logic              geom_valid, div_ready;
   ppg_pkg::geom_type geom_data;
   logic              div_valid, upd_ready;
   ppg_pkg::div_type  div_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ppg_pkg::CSR_SOURCE_X: begin
               cfg_in.source_x = csr_data;
            end
            ppg_pkg::CSR_SOURCE_Y: begin
               cfg_in.source_y = csr_data;
            end
            ppg_pkg::CSR_SOURCE_STRENGTH: begin
               cfg_in.source_strength = csr_data[ppg_pkg::STR_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppg_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (geom_valid),
      .out_ready (div_ready),
      .out_data  (geom_data)
   );

   ppg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (div_ready),
      .in_data   (geom_data),
      .out_valid (div_valid),
      .out_ready (upd_ready),
      .out_data  (div_data)
   );

   ppg_update u_update (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (upd_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // refuse a request only when a result is valid and blocked
   a_refuse_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while the pipeline has room");

   a_geom_hold: assert property (@(posedge clock) disable iff (reset)
      geom_valid && !div_ready |=> geom_valid && $stable(geom_data))
      else $error("distance stage lost or changed a stalled request");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      div_valid && !upd_ready |=> div_valid && $stable(div_data))
      else $error("divider lost or changed a stalled request");
`endif

endmodule

### sim/particle_step_checker.sv
`timescale 1ns / 1ps
// Watches the particle step channels, predicts every updated particle and compares it.
module particle_step_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ppg_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ppg_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ppg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppg_pkg::WORD_W-1:0]     csr_data,
   output int                             fail_count,
   output int                             results_seen
);
   import ppg_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   logic signed [WORD_W-1:0] src_x;
   logic signed [WORD_W-1:0] src_y;
   logic [STR_W-1:0]         src_strength;

   rsp_type pending_steps[$];
   rsp_type want;
   int      bad;

   function automatic longint sat32(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // pull on one axis: |off| * strength * 2^(2*FRAC_BITS) / den3, sign of off
   function automatic longint pull(input longint off, input logic [127:0] den3);
      logic [63:0]  mag;
      logic [127:0] quo;
      if (den3 == 0) return 0;
      mag = (off < 0) ? -off : off;
      quo = ((128'(mag) * 128'(src_strength)) << (2 * FRAC_BITS)) / den3;
      if (quo > 128'd2147483647) return (off < 0) ? SAT_LO : SAT_HI;
      return (off < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
   endfunction

   function automatic rsp_type advance_particle(input req_type r);
      longint       dx, dy, vx, vy, px, py;
      logic [63:0]  mx, my;
      logic [127:0] den3;
      rsp_type      s;
      dx = longint'(src_x) - longint'($signed(r.pos_x));
      dy = longint'(src_y) - longint'($signed(r.pos_y));
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      den3 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
      den3 = den3 * 3;
      vx = sat32(longint'($signed(r.vel_x)) + pull(dx, den3));
      vy = sat32(longint'($signed(r.vel_y)) + pull(dy, den3));
      // one percent damping, truncated toward zero
      vx = vx - vx / 100;
      vy = vy - vy / 100;
      px = sat32(longint'($signed(r.pos_x)) + vx);
      py = sat32(longint'($signed(r.pos_y)) + vy);
      s.new_pos_x = 32'(px);
      s.new_pos_y = 32'(py);
      s.new_vel_x = 32'(vx);
      s.new_vel_y = 32'(vy);
      return s;
   endfunction

   task automatic check_field(input string name, input logic [31:0] w, input logic [31:0] g);
      if (w !== g) begin
         $error("%s: expected %0d, got %0d", name, $signed(w), $signed(g));
         bad++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_x        = '0;
         src_y        = '0;
         src_strength = '0;
         pending_steps.delete();
         fail_count   <= 0;
         results_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SOURCE_X: src_x = csr_data;
               CSR_SOURCE_Y: src_y = csr_data;
               CSR_SOURCE_STRENGTH: src_strength = csr_data[STR_W-1:0];
               default: ;
            endcase
         end
         // append the prediction at the tail of the queue
         if (req_valid && req_ready) begin
            pending_steps.insert(pending_steps.size(), advance_particle(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            bad = 0;
            if (pending_steps.size() == 0) begin
               $error("result with no request waiting: %h", rsp_data);
               bad = 1;
            end else begin
               want = pending_steps.pop_front();
               check_field("new_pos_x", want.new_pos_x, rsp_data.new_pos_x);
               check_field("new_pos_y", want.new_pos_y, rsp_data.new_pos_y);
               check_field("new_vel_x", want.new_vel_x, rsp_data.new_vel_x);
               check_field("new_vel_y", want.new_vel_y, rsp_data.new_vel_y);
            end
            fail_count   <= fail_count + bad;
            results_seen <= results_seen + 1;
         end
      end
   end

endmodule

### sim/particle_point_gravity_step_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the point-attractor particle step, checked beside the block.
module particle_point_gravity_step_top_tb;
   import ppg_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 100;
   localparam int RAND_PHASES = 14;
   localparam int PHASE_ITEMS = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam logic [31:0] W_MAX = 32'h7fffffff;
   localparam logic [31:0] W_MIN = 32'h80000000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data  = '0;

   int          fail_count;
   int          results_seen;
   int          sent        = 0;
   int          idle_cycles = 0;
   bit          burst       = 1'b0;
   logic [31:0] cur_sx      = '0;
   logic [31:0] cur_sy      = '0;

   always #1 clock = ~clock;

   particle_point_gravity_step_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   particle_step_checker step_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .results_seen (results_seen)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: outside burst phases, hold rsp_ready low for a random stall before each result
   initial begin : result_sink
      int stall;
      forever begin
         stall = burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // outside burst phases drop valid for a random gap, then hold valid until the request is taken
   task automatic push_req(input logic [31:0] px, py, vx, vy);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {px, py, vx, vy};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_source(input logic [31:0] sx, sy, input logic [15:0] st);
      write_reg(CSR_SOURCE_X, sx);
      write_reg(CSR_SOURCE_Y, sy);
      // upper data bits carry noise; only the low half is the strength
      write_reg(CSR_SOURCE_STRENGTH, {16'($urandom), st});
      csr_valid <= 1'b0;
      cur_sx = sx;
      cur_sy = sy;
   endtask

   // drop valid, then wait for every outstanding result
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (results_seen < sent) @(posedge clock);
   endtask

   function automatic logic [31:0] near(input logic [31:0] c);
      logic [31:0] off;
      int          k;
      k   = $urandom_range(0, 31);
      off = $urandom & ((32'd1 << k) - 32'd1);
      if ($urandom_range(0, 1)) off = -off;
      return c + off;
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 4))
         0: return W_MAX;
         1: return W_MIN;
         2: return 32'd0;
         3: return 32'hffffffff;
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [31:0] small_word();
      logic [31:0] w;
      w = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1)) w = -w;
      return w;
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no pull: field extremes and damping truncation
      write_reg(CSR_UNUSED, $urandom);
      set_source(32'd0, 32'd0, 16'd0);
      push_req(32'd0, 32'd0, 32'd0, 32'd0);
      push_req(W_MAX, W_MAX, W_MAX, W_MAX);
      push_req(W_MIN, W_MIN, W_MIN, W_MIN);
      push_req(W_MAX, W_MIN, W_MIN, W_MAX);
      push_req(32'd0, 32'd0, 32'hffffffff, 32'd1);
      push_req(32'd0, 32'd0, 32'd99, -32'sd99);
      push_req(32'd0, 32'd0, 32'd100, -32'sd100);
      push_req(32'd0, 32'd0, -32'sd101, 32'd12345);
      finish_phase();

      // full strength at the origin: on the attractor, huge pull, far away
      set_source(32'd0, 32'd0, 16'hffff);
      push_req(32'd0, 32'd0, 32'd5, -32'sd5);
      push_req(32'd1, 32'd0, 32'd0, 32'd0);
      push_req(32'hffffffff, 32'd1, W_MAX, W_MIN);
      push_req(W_MAX, W_MIN, 32'd0, 32'd0);
      push_req(32'h00010000, 32'd0, W_MIN, 32'd0);
      push_req(32'd0, 32'hffff0000, 32'd0, 32'd0);
      finish_phase();

      // attractor at the range corners
      set_source(W_MAX, W_MIN, 16'hffff);
      push_req(W_MIN, W_MAX, 32'd0, 32'd0);
      push_req(W_MAX, W_MIN, W_MAX, W_MIN);
      push_req(32'h7ffffffe, W_MIN, 32'd0, 32'd0);
      finish_phase();

      // weakest pull
      set_source(32'h00010000, 32'hffff0000, 16'd1);
      push_req(32'd0, 32'd0, 32'd0, 32'd0);
      push_req(32'h00010003, 32'hffff0000, 32'd0, 32'd0);
      push_req(32'h00020000, 32'hfffe0000, 32'd1000, -32'sd1000);
      finish_phase();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         logic [31:0] sx, sy;
         logic [15:0] st;
         case ($urandom_range(0, 3))
            0: sx = 32'd0;
            1: sx = corner_word();
            default: sx = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: sy = 32'd0;
            1: sy = corner_word();
            default: sy = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: st = 16'd0;
            1: st = 16'hffff;
            2: st = 16'd1;
            3: st = 16'($urandom_range(1, 255));
            default: st = 16'($urandom);
         endcase
         set_source(sx, sy, st);
         burst = (ph % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            logic [31:0] px, py, vx, vy;
            int          kind;
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
               px = near(cur_sx);
               py = near(cur_sy);
            end else if (kind < 9) begin
               px = $urandom;
               py = $urandom;
            end else begin
               px = corner_word();
               py = corner_word();
            end
            if (kind == 9) begin
               vx = corner_word();
               vy = corner_word();
            end else if ($urandom_range(0, 1)) begin
               vx = small_word();
               vy = small_word();
            end else begin
               vx = $urandom;
               vy = $urandom;
            end
            push_req(px, py, vx, vy);
         end
         finish_phase();
         burst = 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_seen == sent) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
